@@ rtl/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// Profile thermostat sequencer package
// Shared widths, constants, register indexes and divider command and response types.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int PERIODS_DEF     = 4;
   localparam int PERIOD_SLOTS    = 4;
   localparam int PERIOD_IDX_W    = 2;

   localparam int SAMPLE_W        = 10;
   localparam int SUM_W           = 14;
   localparam int TICK_W          = 4;
   localparam int SECONDS_W       = 16;
   localparam int TEMP_W          = 9;
   localparam int OFFSET_W        = 10;
   localparam int DIVISOR_W       = 8;
   localparam int WORD_W          = 26;
   localparam int CSR_IDX_W       = 3;

   // Dividend of the serial divider: the mean of ten samples fits in 11 bits.
   localparam int DIVIDEND_W      = 11;

   localparam logic [TICK_W-1:0]    TICKS_PER_SECOND = TICK_W'(10);
   localparam logic [TEMP_W-1:0]    TEMP_MAX         = TEMP_W'(399);
   localparam logic [DIVIDEND_W-1:0] TEMP_LIMIT      = DIVIDEND_W'(400);

   // Division of the sample sum by ten as a multiplication by 2^19 / 10.
   localparam int                   MEAN_RECIP_W     = 16;
   localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP    = MEAN_RECIP_W'(52429);
   localparam int                   MEAN_SHIFT       = 19;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAL_OFFSET  = 3'd0,
      CSR_CAL_DIVISOR = 3'd1,
      CSR_PERIOD_0    = 3'd2,
      CSR_PERIOD_1    = 3'd3,
      CSR_PERIOD_2    = 3'd4,
      CSR_PERIOD_3    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/pts_if.sv @@
// ----------------------------------------------------------------------------
// Profile thermostat sequencer channels
// Tick request channel and status response channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pts_req_if;
   logic                          valid;
   logic                          ready;
   logic                          key_run;
   logic                          key_clear;
   logic                          key_next;
   logic                          key_prev;
   logic [pts_pkg::SAMPLE_W-1:0]  sample;

   modport source (output valid, key_run, key_clear, key_next, key_prev, sample,
                   input ready);
   modport sink   (input valid, key_run, key_clear, key_next, key_prev, sample,
                   output ready);
endinterface

interface pts_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [pts_pkg::PERIOD_IDX_W-1:0]    period_now;
   logic [pts_pkg::SECONDS_W-1:0]       seconds_now;
   logic [pts_pkg::TEMP_W-1:0]          temperature;
   logic                                running;
   logic                                pump_on;
   logic                                heater_on;
   logic                                cooler_on;

   modport source (output valid, period_now, seconds_now, temperature, running,
                   pump_on, heater_on, cooler_on, input ready);
   modport sink   (input valid, period_now, seconds_now, temperature, running,
                   pump_on, heater_on, cooler_on, output ready);
endinterface

@@ rtl/profile_thermostat_sequencer.sv @@
// ----------------------------------------------------------------------------
// Profile thermostat sequencer
// Runs a temperature program of up to four periods from timer ticks.
// ----------------------------------------------------------------------------
// Each word on req_ch is one timer tick with four key bits and a converter
// sample; each tick gives exactly one status word on rsp_ch. The csr_ port
// writes calibration and the period table; the user must do this only while
// the block is idle, which the block itself does not enforce. A tick's keys,
// time and averaging are registered at acceptance, the expiry check runs in
// the next cycle, and the status word is then loaded into the output
// register in the final step, which raises rsp_ch.valid. Every tenth tick
// also converts the averaged sample to a temperature through the bit-serial
// divider, which loads the operands and then retires one quotient bit at a
// time; the final step waits for its result. No new tick is taken while one
// is in progress, so the divider sets the worst case between ticks.
// A new tick is taken as soon as the previous one is in the output register,
// even while that word waits for rsp_ch.ready; a stalled receiver holds the
// next word in the final step until the output register frees.
// Synchronous reset stops the program, clears time, period, averaging and
// calibration (divisor reads 1) and empties the output register.
// ----------------------------------------------------------------------------
module profile_thermostat_sequencer #(
   parameter int PERIODS = pts_pkg::PERIODS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   pts_req_if.sink                          req_ch,
   pts_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [pts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pts_pkg::WORD_W-1:0]       csr_wdata
);

   localparam int PI_W  = pts_pkg::PERIOD_IDX_W;
   localparam int SEC_W = pts_pkg::SECONDS_W;
   localparam int T_W   = pts_pkg::TEMP_W;
   localparam int N_W   = pts_pkg::DIVIDEND_W;
   localparam int PRD_W = pts_pkg::SUM_W + pts_pkg::MEAN_RECIP_W;
   localparam logic [PI_W:0] PERIOD_COUNT = (PI_W+1)'(PERIODS);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXPIRE = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // Configuration registers.
   logic [pts_pkg::OFFSET_W-1:0]  cal_offset_ff;
   logic [pts_pkg::DIVISOR_W-1:0] cal_divisor_ff;
   logic [pts_pkg::WORD_W-1:0]    period_word_ff [pts_pkg::PERIOD_SLOTS];

   // Program state.
   state_type                     state_ff, state_in;
   logic [pts_pkg::TICK_W-1:0]    tick_ff, tick_in;
   logic [pts_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [pts_pkg::SUM_W-1:0]     total_ff, total_in;
   logic [3:0]                    last_keys_ff, last_keys_in;
   logic [PI_W-1:0]               pi_ff, pi_in;
   logic [SEC_W-1:0]              el_ff, el_in;
   logic [T_W-1:0]                temp_ff, temp_in;
   logic [T_W-1:0]                setpoint_ff, setpoint_in;
   logic                          run_ff, run_in;
   logic                          tenth_ff, tenth_in;
   logic                          drive_ff, drive_in;
   logic                          under_ff, under_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [PI_W-1:0]               out_pi_ff, out_pi_in;
   logic [SEC_W-1:0]              out_el_ff, out_el_in;
   logic [T_W-1:0]                out_temp_ff, out_temp_in;
   logic                          out_run_ff, out_run_in;
   logic                          out_pump_ff, out_pump_in;
   logic                          out_heat_ff, out_heat_in;
   logic                          out_cool_ff, out_cool_in;

   // Tick decode.
   logic [3:0]                    keys;
   logic                          changed;
   logic                          run_a;
   logic                          clear_a;
   logic [PI_W-1:0]               pi_a, pi_b, pi_c;
   logic [SEC_W-1:0]              el_a;
   logic [pts_pkg::TICK_W-1:0]    tick_inc;
   logic                          tenth;
   logic [pts_pkg::SUM_W-1:0]     sum_inc;

   // Expiry and conversion.
   logic [PI_W:0]                 pi_next;
   logic [PRD_W-1:0]              mean_prod;
   logic [N_W-1:0]                mean;
   logic [N_W-1:0]                offset_ext;
   pts_pkg::div_cmd_type          div_cmd;
   pts_pkg::div_rsp_type          div_rsp;
   logic                          out_free;

   pts_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_offset_ff  <= '0;
         cal_divisor_ff <= pts_pkg::DIVISOR_W'(1);
         for (int i = 0; i < pts_pkg::PERIOD_SLOTS; i++) begin
            period_word_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            pts_pkg::CSR_CAL_OFFSET:  cal_offset_ff     <= csr_wdata[pts_pkg::OFFSET_W-1:0];
            pts_pkg::CSR_CAL_DIVISOR: cal_divisor_ff    <= csr_wdata[pts_pkg::DIVISOR_W-1:0];
            pts_pkg::CSR_PERIOD_0:    period_word_ff[0] <= csr_wdata;
            pts_pkg::CSR_PERIOD_1:    period_word_ff[1] <= csr_wdata;
            pts_pkg::CSR_PERIOD_2:    period_word_ff[2] <= csr_wdata;
            pts_pkg::CSR_PERIOD_3:    period_word_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Key handling: the run toggle comes first, and the stopped-only keys see
   // the updated run flag.
   assign keys     = {req_ch.key_prev, req_ch.key_next, req_ch.key_clear, req_ch.key_run};
   assign changed  = keys != last_keys_ff;
   assign run_a    = run_ff ^ (changed & req_ch.key_run);
   assign clear_a  = changed & req_ch.key_clear & ~run_a;
   assign pi_a     = clear_a ? '0 : pi_ff;
   assign el_a     = clear_a ? '0 : el_ff;
   assign pi_b     = (changed && req_ch.key_next && !run_a &&
                      ({1'b0, pi_a} + (PI_W+1)'(1)) < PERIOD_COUNT) ?
                     pi_a + PI_W'(1) : pi_a;
   assign pi_c     = (changed && req_ch.key_prev && !run_a && pi_b != '0) ?
                     pi_b - PI_W'(1) : pi_b;
   assign tick_inc = tick_ff + pts_pkg::TICK_W'(1);
   assign tenth    = tick_inc >= pts_pkg::TICKS_PER_SECOND;
   assign sum_inc  = sum_ff + pts_pkg::SUM_W'(req_ch.sample);

   assign pi_next    = {1'b0, pi_ff} + (PI_W+1)'(1);
   assign mean_prod  = PRD_W'(total_ff) * PRD_W'(pts_pkg::MEAN_RECIP);
   assign mean       = mean_prod[pts_pkg::MEAN_SHIFT +: N_W];
   assign offset_ext = N_W'(cal_offset_ff);
   assign out_free   = ~rsp_valid_ff | rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      sum_in       = sum_ff;
      total_in     = total_ff;
      last_keys_in = last_keys_ff;
      pi_in        = pi_ff;
      el_in        = el_ff;
      temp_in      = temp_ff;
      setpoint_in  = setpoint_ff;
      run_in       = run_ff;
      tenth_in     = tenth_ff;
      drive_in     = drive_ff;
      under_in     = under_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      out_pi_in    = out_pi_ff;
      out_el_in    = out_el_ff;
      out_temp_in  = out_temp_ff;
      out_run_in   = out_run_ff;
      out_pump_in  = out_pump_ff;
      out_heat_in  = out_heat_ff;
      out_cool_in  = out_cool_ff;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = mean - offset_ext;
      div_cmd.divisor  = cal_divisor_ff;
      req_ch.ready     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               last_keys_in = keys;
               run_in       = run_a;
               pi_in        = pi_c;
               total_in     = sum_inc;
               tenth_in     = tenth;
               if (tenth) begin
                  tick_in     = '0;
                  sum_in      = '0;
                  el_in       = run_a ? el_a + SEC_W'(1) : el_a;
                  setpoint_in = period_word_ff[pi_c][16 +: T_W];
               end else begin
                  tick_in = tick_inc;
                  sum_in  = sum_inc;
                  el_in   = el_a;
               end
               state_in = ST_EXPIRE;
            end
         end
         ST_EXPIRE: begin
            drive_in = run_ff;
            if (run_ff && el_ff >= period_word_ff[pi_ff][15:0]) begin
               el_in = '0;
               if (period_word_ff[pi_ff][25]) begin
                  pi_in = '0;
               end else if (pi_next >= PERIOD_COUNT ||
                            period_word_ff[pi_next[PI_W-1:0]][15:0] == '0) begin
                  // Past the table end or at an empty period the program stops.
                  pi_in  = '0;
                  run_in = 1'b0;
               end else begin
                  pi_in = pi_next[PI_W-1:0];
               end
            end
            under_in      = mean < offset_ext;
            div_cmd.start = tenth_ff;
            state_in      = tenth_ff ? ST_DIVIDE : ST_FINISH;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               if (under_ff || div_rsp.quotient >= pts_pkg::TEMP_LIMIT) begin
                  temp_in = pts_pkg::TEMP_MAX;
               end else begin
                  temp_in = div_rsp.quotient[T_W-1:0];
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_pi_in    = pi_ff;
               out_el_in    = el_ff;
               out_temp_in  = temp_ff;
               out_run_in   = run_ff;
               out_pump_in  = drive_ff;
               out_heat_in  = drive_ff & (temp_ff < setpoint_ff);
               out_cool_in  = drive_ff & (temp_ff > setpoint_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         sum_ff       <= '0;
         last_keys_ff <= '0;
         pi_ff        <= '0;
         el_ff        <= '0;
         temp_ff      <= '0;
         setpoint_ff  <= '0;
         run_ff       <= 1'b0;
         tenth_ff     <= 1'b0;
         drive_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         sum_ff       <= sum_in;
         last_keys_ff <= last_keys_in;
         pi_ff        <= pi_in;
         el_ff        <= el_in;
         temp_ff      <= temp_in;
         setpoint_ff  <= setpoint_in;
         run_ff       <= run_in;
         tenth_ff     <= tenth_in;
         drive_ff     <= drive_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff    <= total_in;
      under_ff    <= under_in;
      out_pi_ff   <= out_pi_in;
      out_el_ff   <= out_el_in;
      out_temp_ff <= out_temp_in;
      out_run_ff  <= out_run_in;
      out_pump_ff <= out_pump_in;
      out_heat_ff <= out_heat_in;
      out_cool_ff <= out_cool_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.period_now  = out_pi_ff;
   assign rsp_ch.seconds_now = out_el_ff;
   assign rsp_ch.temperature = out_temp_ff;
   assign rsp_ch.running     = out_run_ff;
   assign rsp_ch.pump_on     = out_pump_ff;
   assign rsp_ch.heater_on   = out_heat_ff;
   assign rsp_ch.cooler_on   = out_cool_ff;

endmodule

@@ rtl/pts_div.sv @@
// ----------------------------------------------------------------------------
// Profile thermostat sequencer serial divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pts_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pts_pkg::div_cmd_type  cmd,
   output pts_pkg::div_rsp_type  rsp
);

   localparam int NUM_W = pts_pkg::DIVIDEND_W;
   localparam int DIV_W = pts_pkg::DIVISOR_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             fits;

   // The dividend register shifts left; quotient bits enter at the bottom.
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         num_in  = cmd.dividend;
         dvs_in  = cmd.divisor;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], fits};
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff;

endmodule

@@ rtl/pts_checker.sv @@
// ----------------------------------------------------------------------------
// Profile thermostat sequencer checker
// Port-level assertions on the status words, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic [pts_pkg::TEMP_W-1:0]   temperature,
   input logic                         running,
   input logic                         pump_on,
   input logic                         heater_on,
   input logic                         cooler_on
);

   // No status word may be left over from before a reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("status word valid right after reset");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> temperature <= pts_pkg::TEMP_MAX)
      else $error("temperature above saturation limit");

   // A program that still runs after the tick was driving during it.
   a_run_pump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && running |-> pump_on)
      else $error("running without pump");

   a_drive_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(heater_on && cooler_on) && (pump_on || (!heater_on && !cooler_on)))
      else $error("heater and cooler drives inconsistent");

endmodule

bind profile_thermostat_sequencer pts_checker u_pts_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .temperature (rsp_ch.temperature),
   .running     (rsp_ch.running),
   .pump_on     (rsp_ch.pump_on),
   .heater_on   (rsp_ch.heater_on),
   .cooler_on   (rsp_ch.cooler_on)
);
